// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the range maximum query tree
// Word formats of both channels, the stored node format and the op codes.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int MAX_LEAVES_DEF = 64;

	localparam int LEAF_COUNT_W = 7;
	localparam int POS_W        = 6;
	localparam int KEY_W        = 32;
	localparam int VALUE_W      = 31;
	localparam int ANSWER_W     = 32;

	localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RESET = 7'd64;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_RANGE  = 2'd3;

	// answer when nothing qualifies
	localparam logic signed [ANSWER_W-1:0] ANSWER_NONE = -32'sd1;

	typedef struct packed {
		logic [1:0]                op;
		logic [POS_W-1:0]          position;
		logic signed [KEY_W-1:0]   key_low;
		logic signed [KEY_W-1:0]   key_high;
		logic [VALUE_W-1:0]        new_value;
	} in_word_t;

	typedef struct packed {
		logic signed [ANSWER_W-1:0] answer;
		logic                       found;
	} out_word_t;

	// one leaf or tree node: max key and max value of the subtree
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [VALUE_W-1:0]      value;
	} node_t;

endpackage

// File: rtl/range_max_query_tree.sv
// ----------------------------------------------------------------------------
// range_max_query_tree: segment tree for range maximum queries over keyed leaves
// The tree over n leaves in use is ceil(log2 n) levels deep, 6 for 64 leaves.
// One word in flight; each level of a walk waits on the registered read of the
// node memory. Reset clears control only; leaf_count resets to 64, memories
// hold no data until loaded. A leaf_count write while idle rebuilds the tree.
// ----------------------------------------------------------------------------
module range_max_query_tree #(
	parameter int MAX_LEAVES = rmq_pkg::MAX_LEAVES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  rmq_pkg::in_word_t                     req,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output rmq_pkg::out_word_t                    rsp,
	input  logic                                  leaf_count_we,
	input  logic [rmq_pkg::LEAF_COUNT_W-1:0]      leaf_count_wdata
);
	import rmq_pkg::*;

	localparam int LW = $clog2(MAX_LEAVES);
	localparam int CW = $clog2(MAX_LEAVES + 1);
	localparam int NW = LW + 1;

	logic [LEAF_COUNT_W-1:0] leaf_count_q;
	logic [CW-1:0]           n_eff;
	logic                    res_valid;
	logic                    res_ready;
	out_word_t               res;
	logic                    rsp_valid_q;
	out_word_t               rsp_q;

	logic [NW-1:0] tr_ra_a;
	logic [NW-1:0] tr_ra_b;
	node_t         tr_rd_a;
	node_t         tr_rd_b;
	logic          tr_we;
	logic [NW-1:0] tr_wa;
	node_t         tr_wd;
	logic          lf_re;
	logic [LW-1:0] lf_ra;
	node_t         lf_rd;
	logic          lf_we;
	logic [LW-1:0] lf_wa;
	node_t         lf_wd;

	// zero means one leaf, anything above the storage means all of it
	always_comb begin
		if (leaf_count_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(leaf_count_q) > 32'(MAX_LEAVES)) begin
			n_eff = CW'(MAX_LEAVES);
		end else begin
			n_eff = CW'(leaf_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= LEAF_COUNT_RESET;
		end else if (leaf_count_we) begin
			leaf_count_q <= leaf_count_wdata;
		end
	end

	// output word register
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	rmq_ctrl #(
		.MAX_LEAVES (MAX_LEAVES),
		.LW         (LW),
		.CW         (CW),
		.NW         (NW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.n             (n_eff),
		.rebuild_start (leaf_count_we),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.tr_ra_a       (tr_ra_a),
		.tr_ra_b       (tr_ra_b),
		.tr_rd_a       (tr_rd_a),
		.tr_rd_b       (tr_rd_b),
		.tr_we         (tr_we),
		.tr_wa         (tr_wa),
		.tr_wd         (tr_wd),
		.lf_re         (lf_re),
		.lf_ra         (lf_ra),
		.lf_rd         (lf_rd),
		.lf_we         (lf_we),
		.lf_wa         (lf_wa),
		.lf_wd         (lf_wd)
	);

	rmq_tree_ram #(
		.NW (NW)
	) u_tree_ram (
		.clk  (clk),
		.ra_a (tr_ra_a),
		.ra_b (tr_ra_b),
		.rd_a (tr_rd_a),
		.rd_b (tr_rd_b),
		.we   (tr_we),
		.wa   (tr_wa),
		.wd   (tr_wd)
	);

	rmq_leaf_ram #(
		.LW (LW)
	) u_leaf_ram (
		.clk (clk),
		.re  (lf_re),
		.ra  (lf_ra),
		.rd  (lf_rd),
		.we  (lf_we),
		.wa  (lf_wa),
		.wd  (lf_wd)
	);

endmodule

// File: rtl/rmq_tree_ram.sv
// ----------------------------------------------------------------------------
// rmq_tree_ram: node memory of the max tree
// Heap layout, root at node 1. Two registered read ports, one write port.
// ----------------------------------------------------------------------------
module rmq_tree_ram #(
	parameter int NW = 7
) (
	input  logic           clk,
	input  logic [NW-1:0]  ra_a,
	input  logic [NW-1:0]  ra_b,
	output rmq_pkg::node_t rd_a,
	output rmq_pkg::node_t rd_b,
	input  logic           we,
	input  logic [NW-1:0]  wa,
	input  rmq_pkg::node_t wd
);
	import rmq_pkg::*;

	localparam int DEPTH = 2 ** NW;

	node_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_a <= mem_q[ra_a];
		rd_b <= mem_q[ra_b];
	end

endmodule

// File: rtl/rmq_leaf_ram.sv
// ----------------------------------------------------------------------------
// rmq_leaf_ram: leaf store indexed by position
// Holds every loaded leaf, in use or not; read back when the tree is rebuilt.
// ----------------------------------------------------------------------------
module rmq_leaf_ram #(
	parameter int LW = 6
) (
	input  logic           clk,
	input  logic           re,
	input  logic [LW-1:0]  ra,
	output rmq_pkg::node_t rd,
	input  logic           we,
	input  logic [LW-1:0]  wa,
	input  rmq_pkg::node_t wd
);
	import rmq_pkg::*;

	localparam int DEPTH = 2 ** LW;

	node_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd <= mem_q[ra];
		end
	end

endmodule

// File: rtl/rmq_ctrl.sv
// ----------------------------------------------------------------------------
// rmq_ctrl: tree walker
// Walks root to leaf through the node memory, one level per registered read,
// writes leaves and fixes ancestors bottom-up, and rebuilds after a count change.
// ----------------------------------------------------------------------------
module rmq_ctrl #(
	parameter int MAX_LEAVES = 64,
	parameter int LW         = 6,
	parameter int CW         = 7,
	parameter int NW         = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CW-1:0]      n,
	input  logic               rebuild_start,
	input  logic               req_valid,
	output logic               req_stall,
	input  rmq_pkg::in_word_t  req,
	output logic               res_valid,
	input  logic               res_ready,
	output rmq_pkg::out_word_t res,
	output logic [NW-1:0]      tr_ra_a,
	output logic [NW-1:0]      tr_ra_b,
	input  rmq_pkg::node_t     tr_rd_a,
	input  rmq_pkg::node_t     tr_rd_b,
	output logic               tr_we,
	output logic [NW-1:0]      tr_wa,
	output rmq_pkg::node_t     tr_wd,
	output logic               lf_re,
	output logic [LW-1:0]      lf_ra,
	input  rmq_pkg::node_t     lf_rd,
	output logic               lf_we,
	output logic [LW-1:0]      lf_wa,
	output rmq_pkg::node_t     lf_wd
);
	import rmq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_POS_WALK,
		ST_DESC_RD,
		ST_DESC_EV,
		ST_LEAF_CHK,
		ST_UP_RD,
		ST_UP_WR,
		ST_REB_RD,
		ST_FINISH
	} state_t;

	// KEY: search by key; SPLIT: find the fork of a range;
	// LEFT / RIGHT: the two boundary paths below the fork
	typedef enum logic [1:0] {
		PH_KEY,
		PH_SPLIT,
		PH_LEFT,
		PH_RIGHT
	} phase_t;

	state_t           state_q;
	phase_t           phase_q;
	in_word_t         item_q;
	out_word_t        res_q;
	logic [NW-1:0]    nd_q;
	logic [CW-1:0]    s_q;
	logic [CW-1:0]    e_q;
	logic [NW-1:0]    sp_nd_q;
	logic [CW-1:0]    sp_s_q;
	logic [CW-1:0]    sp_e_q;
	logic             acc_vld_q;
	logic [VALUE_W-1:0] acc_q;
	logic             rebuild_q;
	logic [LW-1:0]    reb_pos_q;

	logic [CW:0]      sum;
	logic [CW-1:0]    mid;
	logic [CW:0]      sp_sum;
	logic [CW-1:0]    sp_mid;
	logic             at_leaf;
	logic [NW-1:0]    lnode;
	logic [NW-1:0]    rnode;
	logic [NW-1:0]    parent;
	logic [CW-1:0]    walk_tgt;
	logic             lt_l;
	logic             lt_r;
	logic             gt_r;
	logic             key_hit;
	logic             pos_ok;
	logic             pos_in_use;
	logic             upd_hit;
	logic             acc_take;
	logic [VALUE_W-1:0] acc_cand;
	logic             acc_nv;
	logic [VALUE_W-1:0] acc_nx;
	logic signed [ANSWER_W-1:0] range_ans;
	logic             last_leaf;

	always_comb begin
		sum     = {1'b0, s_q} + {1'b0, e_q};
		mid     = sum[CW:1];
		sp_sum  = {1'b0, sp_s_q} + {1'b0, sp_e_q};
		sp_mid  = sp_sum[CW:1];
		at_leaf = (e_q - s_q) <= CW'(1);
		lnode   = {nd_q[NW-2:0], 1'b0};
		rnode   = {nd_q[NW-2:0], 1'b1};
		parent  = {1'b0, nd_q[NW-1:1]};

		walk_tgt = rebuild_q ? CW'(reb_pos_q) : CW'(item_q.position);

		lt_l    = $signed(tr_rd_a.key) < $signed(item_q.key_low);
		lt_r    = $signed(tr_rd_a.key) < $signed(item_q.key_high);
		gt_r    = $signed(tr_rd_a.key) > $signed(item_q.key_high);
		key_hit = $signed(tr_rd_a.key) == $signed(item_q.key_low);

		pos_ok     = 32'(item_q.position) < 32'(MAX_LEAVES);
		pos_in_use = 32'(item_q.position) < 32'(n);
		upd_hit    = (state_q == ST_LEAF_CHK) && (phase_q == PH_KEY) &&
		             (item_q.op == OP_UPDATE) && key_hit;
		last_leaf  = CW'(reb_pos_q) == (n - CW'(1));

		// running maximum along the boundary paths
		acc_take = 1'b0;
		acc_cand = tr_rd_a.value;
		if (state_q == ST_DESC_EV) begin
			if (phase_q == PH_LEFT) begin
				acc_take = !lt_l;
				acc_cand = tr_rd_b.value;
			end else if (phase_q == PH_RIGHT) begin
				acc_take = lt_r;
			end
		end else if (state_q == ST_LEAF_CHK) begin
			if (phase_q == PH_LEFT) begin
				acc_take = !lt_l;
			end else if (phase_q == PH_RIGHT) begin
				acc_take = !gt_r;
			end
		end
		acc_nv    = acc_vld_q | acc_take;
		acc_nx    = (acc_take && (!acc_vld_q || (acc_cand > acc_q))) ? acc_cand : acc_q;
		range_ans = acc_nv ? $signed({1'b0, acc_nx}) : ANSWER_NONE;
	end

	// memory controls
	always_comb begin
		tr_ra_a = at_leaf ? nd_q : lnode;
		tr_ra_b = rnode;
		if (state_q == ST_UP_RD) begin
			tr_ra_a = {nd_q[NW-1:1], 1'b0};
			tr_ra_b = {nd_q[NW-1:1], 1'b1};
		end

		tr_we       = 1'b0;
		tr_wa       = nd_q;
		tr_wd.key   = item_q.key_low;
		tr_wd.value = item_q.new_value;
		if (state_q == ST_UP_WR) begin
			tr_we       = 1'b1;
			tr_wa       = parent;
			tr_wd.key   = ($signed(tr_rd_a.key) < $signed(tr_rd_b.key)) ?
			              tr_rd_b.key : tr_rd_a.key;
			tr_wd.value = (tr_rd_a.value < tr_rd_b.value) ? tr_rd_b.value : tr_rd_a.value;
		end else if (state_q == ST_POS_WALK && at_leaf) begin
			tr_we = 1'b1;
			if (rebuild_q) begin
				tr_wd = lf_rd;
			end
		end else if (upd_hit) begin
			tr_we = 1'b1;
		end

		lf_re = state_q == ST_REB_RD;
		lf_ra = reb_pos_q;
		lf_we = upd_hit ||
		        (state_q == ST_DISPATCH && item_q.op == OP_LOAD && pos_ok);
		lf_wa = (state_q == ST_DISPATCH) ? LW'(item_q.position) : s_q[LW-1:0];
		lf_wd.key   = item_q.key_low;
		lf_wd.value = item_q.new_value;
	end

	assign req_stall = (state_q != ST_IDLE) || rebuild_start;
	assign res_valid = state_q == ST_FINISH;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_KEY;
			item_q    <= '0;
			res_q     <= '0;
			nd_q      <= NW'(1);
			s_q       <= '0;
			e_q       <= CW'(1);
			sp_nd_q   <= NW'(1);
			sp_s_q    <= '0;
			sp_e_q    <= CW'(1);
			acc_vld_q <= 1'b0;
			acc_q     <= '0;
			rebuild_q <= 1'b0;
			reb_pos_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rebuild_start) begin
						rebuild_q <= 1'b1;
						reb_pos_q <= '0;
						state_q   <= ST_REB_RD;
					end else if (req_valid) begin
						item_q  <= req;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					acc_vld_q <= 1'b0;
					res_q     <= '0;
					nd_q      <= NW'(1);
					s_q       <= '0;
					e_q       <= n;
					case (item_q.op)
						OP_LOAD: begin
							state_q <= (pos_ok && pos_in_use) ? ST_POS_WALK : ST_FINISH;
						end
						OP_UPDATE, OP_LOOKUP: begin
							phase_q <= PH_KEY;
							state_q <= ST_DESC_RD;
						end
						default: begin
							if ($signed(item_q.key_low) == $signed(item_q.key_high)) begin
								phase_q <= PH_KEY;
								state_q <= ST_DESC_RD;
							end else if ($signed(item_q.key_low) >
							             $signed(item_q.key_high)) begin
								res_q.answer <= ANSWER_NONE;
								state_q      <= ST_FINISH;
							end else begin
								phase_q <= PH_SPLIT;
								state_q <= ST_DESC_RD;
							end
						end
					endcase
				end
				ST_POS_WALK: begin
					if (at_leaf) begin
						state_q <= ST_UP_RD;
					end else if (walk_tgt < mid) begin
						nd_q <= lnode;
						e_q  <= mid;
					end else begin
						nd_q <= rnode;
						s_q  <= mid;
					end
				end
				ST_DESC_RD: begin
					state_q <= at_leaf ? ST_LEAF_CHK : ST_DESC_EV;
				end
				ST_DESC_EV: begin
					acc_vld_q <= acc_nv;
					acc_q     <= acc_nx;
					state_q   <= ST_DESC_RD;
					if (phase_q == PH_SPLIT && !lt_l && lt_r) begin
						// fork found: left boundary path first
						sp_nd_q <= nd_q;
						sp_s_q  <= s_q;
						sp_e_q  <= e_q;
						phase_q <= PH_LEFT;
						nd_q    <= lnode;
						e_q     <= mid;
					end else if ((phase_q == PH_RIGHT) ? lt_r : lt_l) begin
						nd_q <= rnode;
						s_q  <= mid;
					end else begin
						nd_q <= lnode;
						e_q  <= mid;
					end
				end
				ST_LEAF_CHK: begin
					case (phase_q)
						PH_KEY: begin
							if (item_q.op == OP_UPDATE) begin
								if (key_hit) begin
									res_q.found <= 1'b1;
									state_q     <= ST_UP_RD;
								end else begin
									state_q <= ST_FINISH;
								end
							end else begin
								res_q.answer <= key_hit ?
								                $signed({1'b0, tr_rd_a.value}) : ANSWER_NONE;
								state_q      <= ST_FINISH;
							end
						end
						PH_SPLIT: begin
							res_q.answer <= (lt_l || gt_r) ?
							                ANSWER_NONE : $signed({1'b0, tr_rd_a.value});
							state_q      <= ST_FINISH;
						end
						PH_LEFT: begin
							acc_vld_q <= acc_nv;
							acc_q     <= acc_nx;
							nd_q      <= {sp_nd_q[NW-2:0], 1'b1};
							s_q       <= sp_mid;
							e_q       <= sp_e_q;
							phase_q   <= PH_RIGHT;
							state_q   <= ST_DESC_RD;
						end
						default: begin
							res_q.answer <= range_ans;
							state_q      <= ST_FINISH;
						end
					endcase
				end
				ST_UP_RD: begin
					if (nd_q == NW'(1)) begin
						if (rebuild_q) begin
							if (last_leaf) begin
								rebuild_q <= 1'b0;
								state_q   <= ST_IDLE;
							end else begin
								reb_pos_q <= reb_pos_q + LW'(1);
								state_q   <= ST_REB_RD;
							end
						end else begin
							state_q <= ST_FINISH;
						end
					end else begin
						state_q <= ST_UP_WR;
					end
				end
				ST_UP_WR: begin
					nd_q    <= parent;
					state_q <= ST_UP_RD;
				end
				ST_REB_RD: begin
					nd_q    <= NW'(1);
					s_q     <= '0;
					e_q     <= n;
					state_q <= ST_POS_WALK;
				end
				ST_FINISH: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// cursor interval never empty while walking
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DESC_RD || state_q == ST_POS_WALK) |-> (e_q > s_q))
		else $error("rmq_ctrl: empty cursor interval during walk");

	// a finished result holds until the output register takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_q)))
		else $error("rmq_ctrl: result dropped or changed while waiting");

	// rebuild only runs through its own states and never writes the leaf store
	assert property (@(posedge clk) disable iff (!arst_n)
		rebuild_q |-> (!lf_we && (state_q == ST_REB_RD || state_q == ST_POS_WALK ||
		                          state_q == ST_UP_RD || state_q == ST_UP_WR)))
		else $error("rmq_ctrl: stray state or leaf write during rebuild");

	// a parent write always follows a read of its two children
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP_WR) |-> ($past(state_q) == ST_UP_RD && $past(nd_q) == nd_q))
		else $error("rmq_ctrl: ancestor write without child read");

endmodule

// File: test/range_max_query_tree_tb.sv
// ----------------------------------------------------------------------------
// range_max_query_tree_tb: self-checking bench for the range maximum query tree
// Loads every leaf with ascending keys, runs directed corner cases, then random
// loads, updates, lookups and range queries under several leaf counts and idle
// patterns. A behavioral tree model predicts each answer word for comparison.
// ----------------------------------------------------------------------------
module range_max_query_tree_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rmq_pkg::*;

	localparam int     LEAVES        = MAX_LEAVES_DEF;
	localparam int     NODES         = 4 * MAX_LEAVES_DEF;
	localparam longint KEY_MIN       = -64'sd2147483648;
	localparam longint KEY_MAX       = 64'sd2147483647;
	localparam longint VAL_MAX       = 64'sd2147483647;
	localparam int     WORDS_PER_SET = 50;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     DRAIN_CYCLES  = 60;

	typedef logic signed [KEY_W-1:0]    key_t;
	typedef logic signed [ANSWER_W-1:0] ans_t;

	logic       clk              = 1'b0;
	logic       arst_n           = 1'b0;
	logic       req_valid        = 1'b0;
	logic       req_stall;
	in_word_t   req              = '0;
	logic       rsp_valid;
	logic       rsp_stall        = 1'b0;
	out_word_t  rsp;
	logic       leaf_count_we    = 1'b0;
	logic [LEAF_COUNT_W-1:0] leaf_count_wdata = '0;

	in_word_t   words_to_send[$];
	out_word_t  answers_due[$];
	logic       req_taken        = 1'b0;
	int         send_idle_pct    = 0;
	int         recv_idle_pct    = 0;
	bit         hold_go          = 1'b0;
	bit         hold_done        = 1'b0;
	int         hold_left        = 0;
	int         mismatches       = 0;

	// stimulus-side copy of the leaf keys, tracks the words queued so far
	longint     gen_keys[LEAVES];

	// tree model state
	logic [LEAF_COUNT_W-1:0] leaf_count_cfg = LEAF_COUNT_RESET;
	key_t                    leaf_key[LEAVES];
	logic [VALUE_W-1:0]      leaf_val[LEAVES];
	key_t                    node_key[NODES];
	ans_t                    node_max[NODES];

	range_max_query_tree DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.req              (req),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.rsp              (rsp),
		.leaf_count_we    (leaf_count_we),
		.leaf_count_wdata (leaf_count_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- tree model ----------------

	function automatic int leaves_in_use();
		if (leaf_count_cfg == 0) return 1;
		if (leaf_count_cfg > LEAVES) return LEAVES;
		return int'(leaf_count_cfg);
	endfunction

	// heap layout, node nd covers [lo, hi) and splits at the midpoint
	function automatic void tree_rebuild();
		int lo_of[NODES];
		int hi_of[NODES];
		bit used[NODES];
		int mid;
		foreach (used[i]) used[i] = 1'b0;
		used[1]  = 1'b1;
		lo_of[1] = 0;
		hi_of[1] = leaves_in_use();
		for (int nd = 1; nd < NODES / 2; nd++) begin
			if (used[nd] && hi_of[nd] - lo_of[nd] > 1) begin
				mid = (lo_of[nd] + hi_of[nd]) >> 1;
				used[2*nd]    = 1'b1;
				lo_of[2*nd]   = lo_of[nd];
				hi_of[2*nd]   = mid;
				used[2*nd+1]  = 1'b1;
				lo_of[2*nd+1] = mid;
				hi_of[2*nd+1] = hi_of[nd];
			end
		end
		for (int nd = NODES - 1; nd >= 1; nd--) begin
			if (used[nd]) begin
				if (hi_of[nd] - lo_of[nd] <= 1) begin
					node_key[nd] = leaf_key[lo_of[nd]];
					node_max[nd] = ans_t'({1'b0, leaf_val[lo_of[nd]]});
				end else begin
					node_key[nd] = (node_key[2*nd] < node_key[2*nd+1]) ?
						node_key[2*nd+1] : node_key[2*nd];
					node_max[nd] = (node_max[2*nd] < node_max[2*nd+1]) ?
						node_max[2*nd+1] : node_max[2*nd];
				end
			end
		end
	endfunction

	// walk to the one leaf a key search reaches
	function automatic void tree_descend(input key_t k, output int nd, output int s);
		int e;
		nd = 1;
		s  = 0;
		e  = leaves_in_use();
		while (e - s > 1) begin
			if (node_key[2*nd] < k) begin
				s  = (s + e) >> 1;
				nd = 2 * nd + 1;
			end else begin
				e  = (s + e) >> 1;
				nd = 2 * nd;
			end
		end
	endfunction

	function automatic ans_t tree_lookup(key_t k);
		int nd;
		int s;
		tree_descend(k, nd, s);
		return (node_key[nd] == k) ? node_max[nd] : ANSWER_NONE;
	endfunction

	function automatic ans_t tree_range_max(key_t l, key_t r);
		int   nd, s, e, m;
		int   a_nd, a_s, a_e, b_nd, b_s, b_e, mid;
		ans_t ml, mr;
		bit   split;
		if (l == r) return tree_lookup(l);
		if (l > r) return ANSWER_NONE;
		nd    = 1;
		s     = 0;
		e     = leaves_in_use();
		split = 1'b0;
		// find the node where the two bounds part ways
		while (!split && e - s > 1) begin
			m = (s + e) >> 1;
			if (node_key[2*nd] < l) begin
				nd = 2 * nd + 1;
				s  = m;
			end else if (node_key[2*nd] >= r) begin
				nd = 2 * nd;
				e  = m;
			end else begin
				split = 1'b1;
			end
		end
		if (!split)
			return (node_key[nd] > r || node_key[nd] < l) ? ANSWER_NONE : node_max[nd];
		ml = ANSWER_NONE;
		mr = ANSWER_NONE;
		m  = (s + e) >> 1;
		a_nd = 2 * nd;
		a_s  = s;
		a_e  = m;
		while (a_e - a_s > 1) begin
			mid = (a_s + a_e) >> 1;
			if (node_key[2*a_nd] < l) begin
				a_nd = 2 * a_nd + 1;
				a_s  = mid;
			end else begin
				if (ml < node_max[2*a_nd+1]) ml = node_max[2*a_nd+1];
				a_nd = 2 * a_nd;
				a_e  = mid;
			end
		end
		if (node_key[a_nd] >= l && ml < node_max[a_nd]) ml = node_max[a_nd];
		b_nd = 2 * nd + 1;
		b_s  = m;
		b_e  = e;
		while (b_e - b_s > 1) begin
			mid = (b_s + b_e) >> 1;
			if (node_key[2*b_nd] < r) begin
				if (mr < node_max[2*b_nd]) mr = node_max[2*b_nd];
				b_nd = 2 * b_nd + 1;
				b_s  = mid;
			end else begin
				b_nd = 2 * b_nd;
				b_e  = mid;
			end
		end
		if (node_key[b_nd] <= r && mr < node_max[b_nd]) mr = node_max[b_nd];
		return (mr < ml) ? ml : mr;
	endfunction

	// applies one request word to the model and returns the answer word
	function automatic out_word_t tree_answer(in_word_t w);
		out_word_t o;
		int        nd;
		int        s;
		key_t      kl;
		key_t      kh;
		o.answer = '0;
		o.found  = 1'b0;
		kl = w.key_low;
		kh = w.key_high;
		case (w.op)
			OP_LOAD: begin
				leaf_key[w.position] = kl;
				leaf_val[w.position] = w.new_value;
				tree_rebuild();
			end
			OP_UPDATE: begin
				tree_descend(kl, nd, s);
				if (node_key[nd] == kl) begin
					leaf_val[s] = w.new_value;
					tree_rebuild();
					o.found = 1'b1;
				end
			end
			OP_LOOKUP: o.answer = tree_lookup(kl);
			default:   o.answer = tree_range_max(kl, kh);
		endcase
		return o;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic longint rand_key();
		int k;
		k = $urandom;
		return k;
	endfunction

	function automatic longint rand_between(longint lo, longint hi);
		longint unsigned r;
		longint unsigned span;
		r    = {$urandom, $urandom};
		span = hi - lo + 1;
		return lo + longint'(r % span);
	endfunction

	function automatic longint rand_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 0;
		if (sel == 1) return VAL_MAX;
		return $urandom_range(0, 32'h7FFF_FFFF);
	endfunction

	// mostly keys that exist, some neighbors, extremes and noise
	function automatic longint pick_key(int n);
		int     sel;
		longint k;
		sel = $urandom_range(0, 99);
		k   = gen_keys[$urandom_range(0, n - 1)];
		if (sel < 55) return k;
		if (sel < 70) return $urandom_range(0, 1) ? k + 1 : k - 1;
		if (sel < 80) return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
		return rand_key();
	endfunction

	task automatic add_word(input logic [1:0] op, input int pos, input longint kl,
			input longint kh, input longint val);
		in_word_t w;
		int       k32;
		w.op        = op;
		w.position  = pos[POS_W-1:0];
		w.key_low   = kl[KEY_W-1:0];
		w.key_high  = kh[KEY_W-1:0];
		w.new_value = val[VALUE_W-1:0];
		words_to_send.push_back(w);
		if (op == OP_LOAD) begin
			k32 = kl[31:0];
			gen_keys[pos] = k32;
		end
	endtask

	task automatic add_read(input int n);
		int     sel;
		longint kl;
		longint kh;
		longint tmp;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			add_word(OP_UPDATE, $urandom_range(0, 63), pick_key(n), rand_key(), rand_value());
		end else if (sel < 55) begin
			add_word(OP_LOOKUP, $urandom_range(0, 63), pick_key(n), rand_key(), rand_value());
		end else begin
			kl = pick_key(n);
			kh = ($urandom_range(0, 9) == 0) ? kl : pick_key(n);
			// leave some ranges inverted
			if (kl > kh && $urandom_range(0, 4) != 0) begin
				tmp = kl;
				kl  = kh;
				kh  = tmp;
			end
			add_word(OP_RANGE, $urandom_range(0, 63), kl, kh, rand_value());
		end
	endtask

	task automatic add_random_word(input int n);
		int     sel;
		int     pos;
		longint lo;
		longint hi;
		longint old;
		sel = $urandom_range(0, 99);
		if (sel < 18) begin
			// reload keeping keys ascending across all stored leaves
			pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
			lo  = (pos == 0) ? KEY_MIN : gen_keys[pos-1] + 1;
			hi  = (pos == LEAVES - 1) ? KEY_MAX : gen_keys[pos+1] - 1;
			add_word(OP_LOAD, pos, (hi >= lo) ? rand_between(lo, hi) : gen_keys[pos],
				rand_key(), rand_value());
		end else if (sel < 22) begin
			// out-of-order or repeated key for a few words, then put it back
			pos = $urandom_range(0, n - 1);
			old = gen_keys[pos];
			add_word(OP_LOAD, pos,
				$urandom_range(0, 1) ? gen_keys[$urandom_range(0, n - 1)] : rand_key(),
				rand_key(), rand_value());
			add_read(n);
			add_read(n);
			add_word(OP_LOAD, pos, old, rand_key(), rand_value());
		end else begin
			add_read(n);
		end
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (words_to_send.size() != 0 || req_valid || answers_due.size() != 0);
	endtask

	task automatic write_leaf_count(input int v);
		@(negedge clk);
		leaf_count_we    <= 1'b1;
		leaf_count_wdata <= v[LEAF_COUNT_W-1:0];
		@(negedge clk);
		leaf_count_we    <= 1'b0;
		leaf_count_cfg = v[LEAF_COUNT_W-1:0];
		tree_rebuild();
	endtask

	task automatic load_all_leaves();
		longint keys[LEAVES];
		int     order[LEAVES];
		int     j;
		int     tmp;
		keys[0] = KEY_MIN;
		for (int i = 1; i < LEAVES - 1; i++)
			keys[i] = keys[i-1] + $urandom_range(1, 60000000);
		keys[LEAVES-1] = KEY_MAX;
		foreach (order[i]) order[i] = i;
		for (int i = LEAVES - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i])
			add_word(OP_LOAD, order[i], keys[order[i]], rand_key(), rand_value());
	endtask

	task automatic add_directed();
		longint old;
		add_word(OP_LOOKUP, 0, KEY_MIN, KEY_MAX, 0);
		add_word(OP_LOOKUP, 63, KEY_MAX, KEY_MIN, VAL_MAX);
		add_word(OP_LOOKUP, 1, gen_keys[10] + 1, 0, 0);
		add_word(OP_RANGE, 0, KEY_MIN, KEY_MAX, 0);
		add_word(OP_RANGE, 0, gen_keys[20], gen_keys[10], 0);
		add_word(OP_RANGE, 0, gen_keys[30], gen_keys[30], 0);
		add_word(OP_RANGE, 0, gen_keys[30] + 1, gen_keys[30] + 1, 0);
		add_word(OP_RANGE, 0, gen_keys[3], gen_keys[40], 0);
		// range falling between two neighboring keys
		add_word(OP_RANGE, 0, gen_keys[10] + 1, gen_keys[11] - 1, 0);
		add_word(OP_UPDATE, 0, gen_keys[7], 0, VAL_MAX);
		add_word(OP_UPDATE, 0, gen_keys[8], 0, 0);
		add_word(OP_UPDATE, 0, gen_keys[12] + 1, 0, 5);
		add_word(OP_UPDATE, 0, KEY_MIN, 0, 1234);
		add_word(OP_RANGE, 0, gen_keys[5], gen_keys[9], 0);
		add_word(OP_LOAD, 63, KEY_MAX, 0, 0);
		add_word(OP_LOAD, 32, gen_keys[32], 0, VAL_MAX);
		add_word(OP_RANGE, 0, gen_keys[31], gen_keys[33], 0);
		add_word(OP_RANGE, 0, gen_keys[50], KEY_MAX, 0);
		add_word(OP_RANGE, 0, KEY_MIN, gen_keys[5], 0);
		// repeated key
		old = gen_keys[20];
		add_word(OP_LOAD, 20, gen_keys[40], 0, 77);
		add_word(OP_LOOKUP, 0, gen_keys[40], 0, 0);
		add_word(OP_RANGE, 0, gen_keys[15], gen_keys[45], 0);
		add_word(OP_UPDATE, 0, gen_keys[40], 0, 99);
		add_word(OP_LOAD, 20, old, 0, 55);
		// key out of order
		old = gen_keys[10];
		add_word(OP_LOAD, 10, -5, 0, 4321);
		add_word(OP_LOOKUP, 0, -5, 0, 0);
		add_word(OP_LOAD, 10, old, 0, 66);
	endtask

	// ---------------- request side ----------------

	always @(negedge clk) begin : drive_req
		logic     nxt_valid;
		in_word_t nxt_word;
		nxt_valid = req_valid;
		nxt_word  = req;
		if (!req_valid || req_taken) begin
			if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt_valid = 1'b1;
				nxt_word  = words_to_send.pop_front();
			end else begin
				nxt_valid = 1'b0;
			end
		end
		req_valid <= nxt_valid;
		req       <= nxt_word;
	end

	always @(posedge clk) begin
		req_taken <= req_valid && req_stall === 1'b0;
		if (req_valid && req_stall === 1'b0)
			answers_due.push_back(tree_answer(req));
	end

	// ---------------- response side ----------------

	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_rsp
		out_word_t due;
		if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (answers_due.size() == 0) begin
				$error("unexpected word: answer %0d found %0d", rsp.answer, rsp.found);
				mismatches++;
			end else begin
				due = answers_due.pop_front();
				if (rsp.answer !== due.answer) begin
					$error("answer: expected %0d, got %0d", due.answer, rsp.answer);
					mismatches++;
				end
				if (rsp.found !== due.found) begin
					$error("found: expected %0d, got %0d", due.found, rsp.found);
					mismatches++;
				end
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin : run_test
		int counts[9];
		counts = '{1, 0, 23, 127, 64, 6, 40, 2, 64};
		foreach (leaf_key[i]) begin
			leaf_key[i] = '0;
			leaf_val[i] = '0;
		end
		tree_rebuild();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 30;
		recv_idle_pct = 85;
		@(posedge clk);
		#1;
		// every leaf in use must be written before anything reads it
		load_all_leaves();
		add_directed();
		repeat (WORDS_PER_SET) add_random_word(leaves_in_use());

		foreach (counts[ph]) begin
			wait_idle();
			write_leaf_count(counts[ph]);
			if (ph == 3) begin
				send_idle_pct = 85;
				recv_idle_pct = 30;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			@(posedge clk);
			#1;
			repeat (WORDS_PER_SET) add_random_word(leaves_in_use());
			// long output hold-off while words keep coming
			if (ph == 6) hold_go = 1'b1;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		#1;
		if (mismatches == 0)
			$display("range_max_query_tree: match");
		else
			$display("range_max_query_tree: mismatch");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("range_max_query_tree: mismatch");
		$finish;
	end

endmodule

// File: range_max_query_tree.f
rtl/rmq_pkg.sv
rtl/rmq_tree_ram.sv
rtl/rmq_leaf_ram.sv
rtl/rmq_ctrl.sv
rtl/range_max_query_tree.sv
test/range_max_query_tree_tb.sv
